### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, sampled on clk_i, idle during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset
`define ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### src/kfts_pkg.sv
// ----------------------------------------------------------------------------
// kfts_pkg
// Types, codes and constants shared by the keyframe timeline sequencer.
// ----------------------------------------------------------------------------
package kfts_pkg;

  // Field widths
  localparam int DUR_W     = 24;
  localparam int TICK_W    = 24;
  localparam int TIME_W    = 32;
  localparam int MODE_W    = 2;
  localparam int STAT_W    = 3;
  localparam int FIDX_W    = 3;
  localparam int BLEND_W   = 16;
  localparam int FRAME_W   = DUR_W + 1;  // duration plus loop flag

  // Default table depth
  localparam int MAX_FRAMES_DEF = 8;

  // Shortest accepted duration: 0.01 s in 1/65536 s units
  localparam logic [DUR_W-1:0] MIN_DURATION = 24'd656;

  // Shift-subtract unit step counts
  localparam int STEPS_W = 6;
  localparam logic [STEPS_W-1:0] MOD_STEPS  = 6'd32;
  localparam logic [STEPS_W-1:0] FRAC_STEPS = 6'd16;

  // Command codes
  typedef enum logic [MODE_W-1:0] {
    MODE_ADVANCE = 2'd0,
    MODE_APPEND  = 2'd1,
    MODE_CLEAR   = 2'd2
  } mode_e;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_INTERP    = 3'd0,
    STAT_STATIC    = 3'd1,
    STAT_NO_FRAMES = 3'd2,
    STAT_REJECTED  = 3'd3,
    STAT_ADDED     = 3'd4,
    STAT_CLEARED   = 3'd5,
    STAT_FULL      = 3'd6
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_MOD,
    ST_DIV,
    ST_EMIT
  } state_e;

  // Control to the shift-subtract unit
  typedef struct packed {
    logic               start;
    logic [STEPS_W-1:0] steps;
  } div_ctl_t;

endpackage

### src/kfts_mem.sv
// ----------------------------------------------------------------------------
// kfts_mem
// Keyframe table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kfts_mem #(
  parameter int DEPTH = kfts_pkg::MAX_FRAMES_DEF,
  parameter int AW    = $clog2(kfts_pkg::MAX_FRAMES_DEF)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [kfts_pkg::FRAME_W-1:0] wdata_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [kfts_pkg::FRAME_W-1:0] rdata_o
);

  logic [kfts_pkg::FRAME_W-1:0] mem_q [DEPTH];
  logic [kfts_pkg::FRAME_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/kfts_div.sv
// ----------------------------------------------------------------------------
// kfts_div
// Restoring shift-subtract unit, one bit per cycle. Used for the wrap
// modulo of elapsed time and for the Q0.16 blend factor quotient.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kfts_div #(
  parameter int DIV_W = 27
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  kfts_pkg::div_ctl_t              ctl_i,
  input  logic [DIV_W-1:0]                rem_init_i, // must be below divisor
  input  logic [kfts_pkg::TIME_W-1:0]     num_i,      // bits shifted in, MSB first
  input  logic [DIV_W-1:0]                divisor_i,
  output logic                            done_o,
  output logic [DIV_W-1:0]                rem_o,
  output logic [kfts_pkg::BLEND_W-1:0]    quot_o
);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [kfts_pkg::STEPS_W-1:0]     cnt_q, cnt_d;
  logic [DIV_W-1:0]                 rem_q, rem_d;
  logic [DIV_W-1:0]                 divisor_q, divisor_d;
  logic [kfts_pkg::TIME_W-1:0]      num_q, num_d;
  logic [kfts_pkg::BLEND_W-1:0]     quot_q, quot_d;
  logic [DIV_W:0]                   rem_sh;
  logic                             fits;

  // One step: shift in next bit, subtract when it fits
  assign rem_sh = {rem_q, num_q[kfts_pkg::TIME_W-1]};
  assign fits   = (rem_sh >= {1'b0, divisor_q});

  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    num_d     = num_q;
    quot_d    = quot_q;
    if (ctl_i.start) begin
      busy_d    = 1'b1;
      cnt_d     = ctl_i.steps;
      rem_d     = rem_init_i;
      divisor_d = divisor_i;
      num_d     = num_i;
      quot_d    = '0;
    end else if (busy_q) begin
      rem_d  = fits ? DIV_W'(rem_sh - {1'b0, divisor_q}) : DIV_W'(rem_sh);
      num_d  = {num_q[kfts_pkg::TIME_W-2:0], 1'b0};
      quot_d = {quot_q[kfts_pkg::BLEND_W-2:0], fits};
      cnt_d  = cnt_q - kfts_pkg::STEPS_W'(1);
      if (cnt_q == kfts_pkg::STEPS_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
    num_q     <= num_d;
    quot_q    <= quot_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;
  assign quot_o = quot_q;

  `ASSERT_IMP(a_no_restart, ctl_i.start, !busy_q, "divider restarted while busy")
  `ASSERT_IMP(a_rem_below, done_q, rem_q < divisor_q, "remainder not below divisor")

endmodule

### src/keyframe_timeline_sequencer.sv
// ----------------------------------------------------------------------------
// keyframe_timeline_sequencer
// Keyframe table with elapsed-time tracking and blend factor output.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis channel: tuser carries the command (advance,
//   append, clear), tdata the tick time, frame duration and loop flag. Every
//   command but the unused code answers with one result on m_axis: tuser is
//   the status, tdata the start frame, end frame and Q0.16 blend factor.
//   Append, clear and rejected requests go straight to the output stage.
//   A tick with two or more stored frames walks the table in the memory,
//   one frame a cycle, then runs the 16-step quotient unit or holds on the
//   last frame. When time runs past a looping last frame, a 32-step modulo
//   on the same unit and a second walk come first.
//   One request is in flight at a time; s_axis_tready is high only while the
//   sequencer waits for a request. Results sit in an output register, so the
//   next request is taken while a result still waits; a stalled receiver
//   holds back only the next result.
//   Reset empties the table and zeroes the elapsed time; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keyframe_timeline_sequencer #(
  parameter int MAX_FRAMES = kfts_pkg::MAX_FRAMES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // tick_time[23:0], frame_duration[47:24],
                                     // loop_flag[48], zero pad [55:49]
  input  logic [1:0]  s_axis_tuser,  // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // start_frame[2:0], end_frame[5:3],
                                     // blend_factor[21:6], zero pad [23:22]
  output logic [2:0]  m_axis_tuser   // status[2:0]
);

  localparam int IdxW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CntW = $clog2(MAX_FRAMES + 1);
  localparam int TotW = kfts_pkg::DUR_W + IdxW;
  localparam int CmpW = ((TotW > kfts_pkg::TIME_W) ? TotW : kfts_pkg::TIME_W) + 1;

  // Request fields
  logic                           in_acc;
  kfts_pkg::mode_e                in_mode;
  logic [kfts_pkg::TICK_W-1:0]    in_tick;
  logic [kfts_pkg::DUR_W-1:0]     in_dur;
  logic                           in_loop;

  // Sequencer state
  kfts_pkg::state_e               state_q, state_d;
  logic [CntW-1:0]                count_q, count_d;
  logic [TotW-1:0]                total_q, total_d;
  logic [kfts_pkg::TIME_W-1:0]    elapsed_q, elapsed_d;
  logic [IdxW-1:0]                idx_q, idx_d;
  logic [TotW-1:0]                sum_q, sum_d;
  logic                           wrapped_q, wrapped_d;

  // Pending result
  kfts_pkg::status_e              res_status_q, res_status_d;
  logic [kfts_pkg::FIDX_W-1:0]    res_start_q, res_start_d;
  logic [kfts_pkg::FIDX_W-1:0]    res_end_q, res_end_d;
  logic [kfts_pkg::BLEND_W-1:0]   res_blend_q, res_blend_d;

  // Output register
  logic                           m_valid_q, m_valid_d;
  logic [23:0]                    m_data_q;
  logic [2:0]                     m_user_q;
  logic                           out_load;

  // Memory and divider hookup
  logic                           mem_we;
  logic [kfts_pkg::FRAME_W-1:0]   mem_rdata;
  logic [kfts_pkg::DUR_W-1:0]     rd_len;
  logic                           rd_loop;
  kfts_pkg::div_ctl_t             div_ctl;
  logic [TotW-1:0]                div_rem_init;
  logic [kfts_pkg::TIME_W-1:0]    div_num;
  logic [TotW-1:0]                div_divisor;
  logic                           div_done;
  logic [TotW-1:0]                div_rem;
  logic [kfts_pkg::BLEND_W-1:0]   div_quot;

  // Walk arithmetic
  logic [TotW-1:0]                sum_new;
  logic                           expired_not;
  logic [CntW-1:0]                idx_next;
  logic                           idx_is_last;
  logic [kfts_pkg::TIME_W:0]      elapsed_add;
  logic [kfts_pkg::DUR_W-1:0]     into;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign in_mode = kfts_pkg::mode_e'(s_axis_tuser);
  assign in_tick = s_axis_tdata[23:0];
  assign in_dur  = s_axis_tdata[47:24];
  assign in_loop = s_axis_tdata[48];

  assign rd_len  = mem_rdata[kfts_pkg::DUR_W-1:0];
  assign rd_loop = mem_rdata[kfts_pkg::DUR_W];

  assign sum_new     = sum_q + TotW'(rd_len);
  assign expired_not = (CmpW'(sum_new) > CmpW'(elapsed_q));
  assign idx_next    = CntW'(idx_q) + CntW'(1);
  assign idx_is_last = (idx_next == count_q);
  assign elapsed_add = {1'b0, elapsed_q} + (kfts_pkg::TIME_W + 1)'(in_tick);
  assign into        = kfts_pkg::DUR_W'(elapsed_q - kfts_pkg::TIME_W'(sum_q));

  // Keyframe table
  kfts_mem #(
    .DEPTH (MAX_FRAMES),
    .AW    (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i ({in_loop, in_dur}),
    .raddr_i (idx_d),
    .rdata_o (mem_rdata)
  );

  // Shared modulo / quotient unit
  kfts_div #(
    .DIV_W (TotW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .rem_init_i (div_rem_init),
    .num_i      (div_num),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .rem_o      (div_rem),
    .quot_o     (div_quot)
  );

  assign s_axis_tready = (state_q == kfts_pkg::ST_IDLE);

  // Next state and datapath control
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    total_d      = total_q;
    elapsed_d    = elapsed_q;
    idx_d        = idx_q;
    sum_d        = sum_q;
    wrapped_d    = wrapped_q;
    res_status_d = res_status_q;
    res_start_d  = res_start_q;
    res_end_d    = res_end_q;
    res_blend_d  = res_blend_q;
    mem_we       = 1'b0;
    div_ctl      = '0;
    div_rem_init = '0;
    div_num      = '0;
    div_divisor  = '0;
    out_load     = 1'b0;

    case (state_q)
      kfts_pkg::ST_IDLE: begin
        idx_d = '0;
        if (in_acc) begin
          res_start_d = '0;
          res_end_d   = '0;
          res_blend_d = '0;
          state_d     = kfts_pkg::ST_EMIT;
          case (in_mode)
            kfts_pkg::MODE_ADVANCE: begin
              if (count_q == '0) begin
                elapsed_d    = '0;
                res_status_d = kfts_pkg::STAT_NO_FRAMES;
              end else if (count_q == CntW'(1)) begin
                elapsed_d    = '0;
                res_status_d = kfts_pkg::STAT_STATIC;
              end else begin
                // saturating add, then walk from frame 0
                elapsed_d = elapsed_add[kfts_pkg::TIME_W] ? '1
                                                          : elapsed_add[kfts_pkg::TIME_W-1:0];
                sum_d     = '0;
                wrapped_d = 1'b0;
                state_d   = kfts_pkg::ST_WALK;
              end
            end
            kfts_pkg::MODE_APPEND: begin
              if (in_dur < kfts_pkg::MIN_DURATION) begin
                res_status_d = kfts_pkg::STAT_REJECTED;
              end else if (count_q == CntW'(MAX_FRAMES)) begin
                res_status_d = kfts_pkg::STAT_FULL;
              end else begin
                mem_we       = 1'b1;
                count_d      = count_q + CntW'(1);
                total_d      = total_q + TotW'(in_dur);
                res_status_d = kfts_pkg::STAT_ADDED;
              end
            end
            kfts_pkg::MODE_CLEAR: begin
              count_d      = '0;
              total_d      = '0;
              res_status_d = kfts_pkg::STAT_CLEARED;
            end
            default: begin
              // unused code: no result
              state_d = kfts_pkg::ST_IDLE;
            end
          endcase
        end
      end

      kfts_pkg::ST_WALK: begin
        // memory data belongs to idx_q
        if (expired_not) begin
          res_status_d = kfts_pkg::STAT_INTERP;
          res_start_d  = kfts_pkg::FIDX_W'(idx_q);
          res_end_d    = idx_is_last ? '0 : kfts_pkg::FIDX_W'(idx_next);
          div_ctl      = '{start: 1'b1, steps: kfts_pkg::FRAC_STEPS};
          div_rem_init = TotW'(into);
          div_divisor  = TotW'(rd_len);
          state_d      = kfts_pkg::ST_DIV;
        end else if (idx_is_last) begin
          if (rd_loop && !wrapped_q) begin
            div_ctl      = '{start: 1'b1, steps: kfts_pkg::MOD_STEPS};
            div_num      = elapsed_q;
            div_divisor  = total_q;
            state_d      = kfts_pkg::ST_MOD;
          end else begin
            // hold on the last frame
            res_status_d = kfts_pkg::STAT_STATIC;
            res_start_d  = kfts_pkg::FIDX_W'(idx_q);
            res_end_d    = kfts_pkg::FIDX_W'(idx_q);
            res_blend_d  = '0;
            state_d      = kfts_pkg::ST_EMIT;
          end
        end else begin
          idx_d = idx_next[IdxW-1:0];
          sum_d = sum_new;
        end
      end

      kfts_pkg::ST_MOD: begin
        if (div_done) begin
          elapsed_d = kfts_pkg::TIME_W'(div_rem);
          idx_d     = '0;
          sum_d     = '0;
          wrapped_d = 1'b1;
          state_d   = kfts_pkg::ST_WALK;
        end
      end

      kfts_pkg::ST_DIV: begin
        if (div_done) begin
          res_blend_d = div_quot;
          state_d     = kfts_pkg::ST_EMIT;
        end
      end

      kfts_pkg::ST_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = kfts_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = kfts_pkg::ST_IDLE;
      end
    endcase
  end

  // Output valid
  always_comb begin
    m_valid_d = m_valid_q && !m_axis_tready;
    if (out_load) begin
      m_valid_d = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= kfts_pkg::ST_IDLE;
      count_q   <= '0;
      total_q   <= '0;
      elapsed_q <= '0;
      idx_q     <= '0;
      wrapped_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      total_q   <= total_d;
      elapsed_q <= elapsed_d;
      idx_q     <= idx_d;
      wrapped_q <= wrapped_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    sum_q        <= sum_d;
    res_status_q <= res_status_d;
    res_start_q  <= res_start_d;
    res_end_q    <= res_end_d;
    res_blend_q  <= res_blend_d;
    if (out_load) begin
      m_data_q <= {2'b00, res_blend_q, res_end_q, res_start_q};
      m_user_q <= res_status_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  `ASSERT_NOW(a_count_range, count_q <= CntW'(MAX_FRAMES), "frame count above table depth")
  `ASSERT_IMP(a_empty_total, count_q == '0, total_q == '0, "empty table with nonzero total")
  `ASSERT_IMP(a_walk_frames, state_q == kfts_pkg::ST_WALK, count_q >= CntW'(2),
              "table walk with fewer than two frames")

endmodule

### tb/sv/tb_keyframe_timeline_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyframe_timeline_sequencer
// Self-checking bench for the keyframe timeline sequencer. Commands go in on
// the request stream; a scoreboard predicts the pose each one yields and
// checks every result, field by field, in order. A directed opening covers
// the boundary cases, then random keyframe programs and noise follow, with
// random gaps on both streams and one long stall on the result side.
// ----------------------------------------------------------------------------
module tb_keyframe_timeline_sequencer;

  localparam int TABLE_DEPTH = kfts_pkg::MAX_FRAMES_DEF;
  localparam logic [kfts_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int TARGET_ITEMS = 1050;

  // One command as it travels on the request stream
  typedef struct {
    logic [kfts_pkg::MODE_W-1:0] mode;
    logic [kfts_pkg::TICK_W-1:0] tick;
    logic [kfts_pkg::DUR_W-1:0]  dur;
    logic                        lp;
  } cmd_t;

  // One pose as reported on the result stream
  typedef struct {
    kfts_pkg::status_e            status;
    logic [kfts_pkg::FIDX_W-1:0]  start_frame;
    logic [kfts_pkg::FIDX_W-1:0]  end_frame;
    logic [kfts_pkg::BLEND_W-1:0] blend;
  } pose_t;

  // Timeline scoreboard: own copy of the keyframe table and the clock
  class timeline_scoreboard;
    logic [kfts_pkg::DUR_W-1:0]  lengths [TABLE_DEPTH];
    logic                        loops   [TABLE_DEPTH];
    int unsigned                 count;
    logic [27:0]                 total;
    logic [kfts_pkg::TIME_W-1:0] elapsed;
    pose_t                       pending_poses [$];
    int errors, requests, results, wraps, saturations, holds, fulls, rejects, interps;

    function new();
      count = 0;
      total = '0;
      elapsed = '0;
      errors = 0;
      requests = 0;
      results = 0;
      wraps = 0;
      saturations = 0;
      holds = 0;
      fulls = 0;
      rejects = 0;
      interps = 0;
    endfunction

    // First keyframe not yet expired at the current elapsed time
    function bit locate(output pose_t p);
      logic [kfts_pkg::TIME_W:0] acc;
      logic [kfts_pkg::TIME_W:0] prev;
      logic [kfts_pkg::TIME_W:0] into;
      logic [39:0]               num;
      logic [39:0]               quot;
      acc = '0;
      p = '{status: kfts_pkg::STAT_INTERP, start_frame: '0, end_frame: '0, blend: '0};
      for (int i = 0; i < count; i++) begin
        prev = acc;
        acc  = acc + lengths[i];
        if (acc > {1'b0, elapsed}) begin
          into = {1'b0, elapsed} - prev;
          num  = {into[23:0], 16'h0000};
          quot = num / {16'h0000, lengths[i]};
          p.start_frame = 3'(i);
          p.end_frame   = (i + 1 >= count) ? '0 : 3'(i + 1);
          p.blend       = (quot > 40'hFFFF) ? 16'hFFFF : quot[15:0];
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // Work out the pose an accepted request produces and queue it
    function void note_request(cmd_t c);
      pose_t                     p;
      logic [kfts_pkg::TIME_W:0] sum;
      int unsigned               last;
      bit                        found;
      p = '{status: kfts_pkg::STAT_INTERP, start_frame: '0, end_frame: '0, blend: '0};
      if (c.mode == MODE_UNUSED) return;
      requests++;
      case (c.mode)
        kfts_pkg::MODE_ADVANCE: begin
          if (count == 0) begin
            elapsed  = '0;
            p.status = kfts_pkg::STAT_NO_FRAMES;
          end else if (count == 1) begin
            elapsed  = '0;
            p.status = kfts_pkg::STAT_STATIC;
          end else begin
            sum = {1'b0, elapsed} + c.tick;
            if (sum[kfts_pkg::TIME_W]) begin
              elapsed = '1;
              saturations++;
            end else begin
              elapsed = sum[kfts_pkg::TIME_W-1:0];
            end
            last  = count - 1;
            found = locate(p);
            // past the end with a looping last frame: wrap and search again
            if (!found && loops[last] && total != 0) begin
              elapsed = elapsed % total;
              wraps++;
              found = locate(p);
            end
            if (!found) begin
              p.status      = kfts_pkg::STAT_STATIC;
              p.start_frame = 3'(last);
              p.end_frame   = 3'(last);
              holds++;
            end else begin
              interps++;
            end
          end
        end
        kfts_pkg::MODE_APPEND: begin
          if (c.dur < kfts_pkg::MIN_DURATION) begin
            p.status = kfts_pkg::STAT_REJECTED;
            rejects++;
          end else if (count >= TABLE_DEPTH) begin
            p.status = kfts_pkg::STAT_FULL;
            fulls++;
          end else begin
            lengths[count] = c.dur;
            loops[count]   = c.lp;
            count++;
            total    = total + c.dur;
            p.status = kfts_pkg::STAT_ADDED;
          end
        end
        default: begin
          count    = 0;
          total    = '0;
          p.status = kfts_pkg::STAT_CLEARED;
        end
      endcase
      pending_poses = {pending_poses, p};
    endfunction

    // Compare a result with the oldest expected pose
    function void check_result(logic [kfts_pkg::STAT_W-1:0] st,
                               logic [kfts_pkg::FIDX_W-1:0] sf,
                               logic [kfts_pkg::FIDX_W-1:0] ef,
                               logic [kfts_pkg::BLEND_W-1:0] bf);
      pose_t p;
      results++;
      if (pending_poses.size() == 0) begin
        $error("result with no request pending: status %0d", st);
        errors++;
        return;
      end
      p = pending_poses.pop_front();
      if (st !== p.status) begin
        $error("status: expected %0d, got %0d", p.status, st);
        errors++;
      end
      if (sf !== p.start_frame) begin
        $error("start_frame: expected %0d, got %0d", p.start_frame, sf);
        errors++;
      end
      if (ef !== p.end_frame) begin
        $error("end_frame: expected %0d, got %0d", p.end_frame, ef);
        errors++;
      end
      if (bf !== p.blend) begin
        $error("blend_factor: expected %0d, got %0d", p.blend, bf);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;   // tick_time[23:0], frame_duration[47:24],
                                    // loop_flag[48], zero pad [55:49]
  logic [1:0]  s_axis_tuser = '0;   // mode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // start_frame[2:0], end_frame[5:3],
                                    // blend_factor[21:6], zero pad [23:22]
  logic [2:0]  m_axis_tuser;        // status[2:0]

  timeline_scoreboard sb;
  cmd_t stim [$];
  int   built = 0;
  int   idle_cycles = 0;

  keyframe_timeline_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Queue one command; the unused mode does not count towards the total
  task automatic add_cmd(logic [kfts_pkg::MODE_W-1:0] mode,
                         logic [kfts_pkg::TICK_W-1:0] tick,
                         logic [kfts_pkg::DUR_W-1:0] dur, logic lp);
    cmd_t c;
    c = '{mode: mode, tick: tick, dur: dur, lp: lp};
    stim = {stim, c};
    if (mode != MODE_UNUSED) built++;
  endtask

  // Random tick: zero, maximum, anything, or small against typical tables
  function automatic logic [kfts_pkg::TICK_W-1:0] pick_tick();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 24'hFFFFFF;
      2:       return kfts_pkg::TICK_W'($urandom());
      default: return kfts_pkg::TICK_W'($urandom_range(0, 3000));
    endcase
  endfunction

  // Random duration: mostly short and valid, some rejected, some anything
  function automatic logic [kfts_pkg::DUR_W-1:0] pick_dur();
    case ($urandom_range(0, 9))
      0:       return kfts_pkg::DUR_W'($urandom_range(0, 655));
      1:       return kfts_pkg::DUR_W'($urandom());
      default: return kfts_pkg::DUR_W'($urandom_range(656, 6000));
    endcase
  endfunction

  // Stimulus, drive and end of run
  initial begin
    int  gap;
    int  nfr;
    int  nticks;
    bit  long_run_done;
    long_run_done = 1'b0;
    sb = new();

    // directed: empty table, duration limits, single frame
    add_cmd(kfts_pkg::MODE_ADVANCE, 24'd100, 24'd0, 1'b0);
    add_cmd(kfts_pkg::MODE_APPEND, 24'd0, 24'd0, 1'b1);
    add_cmd(kfts_pkg::MODE_APPEND, 24'd0, 24'd655, 1'b0);
    add_cmd(kfts_pkg::MODE_APPEND, 24'd0, kfts_pkg::MIN_DURATION, 1'b0);
    add_cmd(kfts_pkg::MODE_ADVANCE, 24'hFFFFFF, 24'd0, 1'b0);
    // two frames, last one longest and looping
    add_cmd(kfts_pkg::MODE_APPEND, 24'd0, 24'hFFFFFF, 1'b1);
    add_cmd(kfts_pkg::MODE_ADVANCE, 24'd0, 24'd0, 1'b0);
    add_cmd(kfts_pkg::MODE_ADVANCE, 24'd655, 24'd0, 1'b0);
    add_cmd(kfts_pkg::MODE_ADVANCE, 24'd1, 24'd0, 1'b0);
    // lands exactly on the end time: must wrap to zero
    add_cmd(kfts_pkg::MODE_ADVANCE, 24'hFFFFFF, 24'd0, 1'b0);
    add_cmd(MODE_UNUSED, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
    add_cmd(kfts_pkg::MODE_CLEAR, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
    // fill the table, last frame holding, then one too many
    for (int i = 0; i < TABLE_DEPTH; i++)
      add_cmd(kfts_pkg::MODE_APPEND, 24'd0, kfts_pkg::DUR_W'(1000 * (i + 1)),
              (i != TABLE_DEPTH - 1) && i[0]);
    add_cmd(kfts_pkg::MODE_APPEND, 24'd0, 24'd1000, 1'b0);
    add_cmd(kfts_pkg::MODE_ADVANCE, 24'hFFFFFF, 24'd0, 1'b0);
    add_cmd(kfts_pkg::MODE_ADVANCE, 24'hFFFFFF, 24'd0, 1'b0);

    // random keyframe programs with some noise between them
    while (built < TARGET_ITEMS) begin
      if (!long_run_done && built >= 450) begin
        // hold long enough for the elapsed time to saturate, then wrap
        long_run_done = 1'b1;
        add_cmd(kfts_pkg::MODE_CLEAR, pick_tick(), pick_dur(), 1'b0);
        add_cmd(kfts_pkg::MODE_APPEND, 24'd0, 24'd700, 1'b0);
        add_cmd(kfts_pkg::MODE_APPEND, 24'd0, 24'd900, 1'b0);
        repeat (270) add_cmd(kfts_pkg::MODE_ADVANCE, 24'hFFFFFF, pick_dur(), 1'($urandom()));
        add_cmd(kfts_pkg::MODE_APPEND, 24'd0, 24'd1200, 1'b0);
        add_cmd(kfts_pkg::MODE_APPEND, 24'd0, 24'd1500, 1'b1);
        repeat (3) add_cmd(kfts_pkg::MODE_ADVANCE, pick_tick(), 24'd0, 1'b0);
      end else if ($urandom_range(0, 99) < 80) begin
        if ($urandom_range(0, 3) != 0)
          add_cmd(kfts_pkg::MODE_CLEAR, kfts_pkg::TICK_W'($urandom()),
                  kfts_pkg::DUR_W'($urandom()), 1'($urandom()));
        nfr = $urandom_range(0, TABLE_DEPTH + 1);
        repeat (nfr) add_cmd(kfts_pkg::MODE_APPEND, kfts_pkg::TICK_W'($urandom()),
                             pick_dur(), 1'($urandom()));
        nticks = $urandom_range(1, 16);
        repeat (nticks) add_cmd(kfts_pkg::MODE_ADVANCE, pick_tick(),
                                kfts_pkg::DUR_W'($urandom()), 1'($urandom()));
      end else begin
        repeat ($urandom_range(1, 4))
          add_cmd(kfts_pkg::MODE_W'($urandom()), kfts_pkg::TICK_W'($urandom()),
                  kfts_pkg::DUR_W'($urandom()), 1'($urandom()));
      end
    end

    // reset
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // request side; every fourth stretch of 64 runs without gaps
    foreach (stim[n]) begin
      gap = (((n / 64) % 4) == 3) ? 0 : $urandom_range(0, 7);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
      @(negedge clk_i);
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {7'b0, stim[n].lp, stim[n].dur, stim[n].tick};
      s_axis_tuser  <= stim[n].mode;
      do @(posedge clk_i); while (!s_axis_tready);
      sb.note_request(stim[n]);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    // drain, then give stray results a chance to show up
    while (sb.pending_poses.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);

    $display("Ran %0d requests, %0d results: %0d interpolations, %0d holds, %0d wraps.",
             sb.requests, sb.results, sb.interps, sb.holds, sb.wraps);
    $display("Saturated ticks %0d, full-table appends %0d, rejected appends %0d.",
             sb.saturations, sb.fulls, sb.rejects);
    if (sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Result side: random stalls, bursts without stalls, one long hold-off
  initial begin
    int stall;
    bit held_off;
    held_off = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = (((sb.results / 64) % 4) == 1) ? 0 : $urandom_range(0, 7);
      if (!held_off && sb.results >= 300) begin
        held_off = 1'b1;
        stall = HOLD_CYCLES;
      end
      repeat (stall) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[5:3],
                      m_axis_tdata[21:6]);
    end
  end

  // Watchdog: too long without any transfer on either stream
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
